### rtl/core/cdc_pkg.sv
package cdc_pkg;

	localparam logic [3:0]  DEF_MONTH = 4'd5;
	localparam logic [4:0]  DEF_DAY   = 5'd11;
	localparam logic [13:0] DEF_YEAR  = 14'd1959;
	localparam logic [13:0] YEAR_MIN  = 14'd1;
	localparam logic [13:0] YEAR_MAX  = 14'd9999;
	localparam int          APART_LIM = 4000000;

	localparam int DIV_NUM_W = 32;
	localparam int DIV_DEN_W = 21;
	localparam int DIV_QUO_W = 20;

	// constant divisors seen by the shared divider
	localparam logic [DIV_DEN_W-1:0] DIV_GREG = 21'd146097;
	localparam logic [DIV_DEN_W-1:0] DIV_JUL  = 21'd1461001;
	localparam logic [DIV_DEN_W-1:0] DIV_MON  = 21'd2447;
	localparam logic [DIV_DEN_W-1:0] DIV_DAY  = 21'd80;
	localparam logic [DIV_DEN_W-1:0] DIV_YR   = 21'd11;
	localparam logic [DIV_DEN_W-1:0] DIV_WEEK = 21'd7;

	// floor(2^32 / divisor); estimate is exact or one low for any 32-bit numerator
	localparam logic [31:0] RCP_GREG = 32'((64'd1 << 32) / 64'(DIV_GREG));
	localparam logic [31:0] RCP_JUL  = 32'((64'd1 << 32) / 64'(DIV_JUL));
	localparam logic [31:0] RCP_MON  = 32'((64'd1 << 32) / 64'(DIV_MON));
	localparam logic [31:0] RCP_DAY  = 32'((64'd1 << 32) / 64'(DIV_DAY));
	localparam logic [31:0] RCP_YR   = 32'((64'd1 << 32) / 64'(DIV_YR));
	localparam logic [31:0] RCP_WEEK = 32'((64'd1 << 32) / 64'(DIV_WEEK));

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	// floor(367 * (m - 2 - 12a) / 12), a = -1 for months up to February
	function automatic logic [8:0] month_term(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd0:    r = 9'd305;
			4'd1:    r = 9'd336;
			4'd2:    r = 9'd367;
			4'd3:    r = 9'd30;
			4'd4:    r = 9'd61;
			4'd5:    r = 9'd91;
			4'd6:    r = 9'd122;
			4'd7:    r = 9'd152;
			4'd8:    r = 9'd183;
			4'd9:    r = 9'd214;
			4'd10:   r = 9'd244;
			4'd11:   r = 9'd275;
			4'd12:   r = 9'd305;
			4'd13:   r = 9'd336;
			4'd14:   r = 9'd367;
			default: r = 9'd397;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/cdc_if.sv
interface cdc_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [3:0]  date_month;
	logic [4:0]  date_day;
	logic [13:0] date_year;
	logic signed [20:0] day_offset;

	modport source (output valid, req_type, date_month, date_day, date_year, day_offset,
		input ready);
	modport sink (input valid, req_type, date_month, date_day, date_year, day_offset,
		output ready);
endinterface

interface cdc_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  cur_month;
	logic [4:0]  cur_day;
	logic [13:0] cur_year;
	logic [8:0]  year_day;
	logic [2:0]  week_day;
	logic signed [22:0] days_apart;
	logic        date_rejected;

	modport source (output valid, cur_month, cur_day, cur_year, year_day, week_day,
		days_apart, date_rejected, input ready);
	modport sink (input valid, cur_month, cur_day, cur_year, year_day, week_day,
		days_apart, date_rejected, output ready);
endinterface

### rtl/core/cdc_daynum.sv
// Two-stage day number: terms registered in stage one, jd in stage two
module cdc_daynum (
	input  logic        clk,
	input  logic [3:0]  m,
	input  logic [4:0]  d,
	input  logic [13:0] y,
	output logic [22:0] jd
);

	logic [14:0] yx;
	logic [14:0] yc;
	logic [24:0] p1_s1;
	logic [26:0] p2_s1;
	logic [9:0]  td_s1;
	logic [7:0]  cent;
	logic [9:0]  t3;
	logic [22:0] jd_s2;

	assign yx = 15'(y) + ((m <= 4'd2) ? 15'd4799 : 15'd4800);
	assign yc = yx + 15'd100;

	always_ff @(posedge clk) begin
		p1_s1 <= 25'(yx) * 25'd1461;
		// x/100 as x*5243 >> 19, exact for x below 25600
		p2_s1 <= 27'(yc) * 27'd5243;
		td_s1 <= 10'(cdc_pkg::month_term(m)) + 10'(d);
	end

	assign cent = p2_s1[26:19];
	assign t3   = (10'(cent) * 10'd3) >> 2;

	always_ff @(posedge clk) begin
		jd_s2 <= 23'(24'(p1_s1[24:2]) + 24'(td_s1) - 24'(t3) - 24'd32075);
	end

	assign jd = jd_s2;

endmodule

### rtl/core/cdc_div.sv
// Divide by one of the fixed divisors: reciprocal multiply, then one correction.
// busy rises the cycle after start and falls once quo and rem are registered.
module cdc_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cdc_pkg::div_req_t                   req,
	output logic                                busy,
	output logic [cdc_pkg::DIV_QUO_W-1:0]       quo,
	output logic [cdc_pkg::DIV_DEN_W-1:0]       rem
);

	logic [cdc_pkg::DIV_NUM_W-1:0] num_q;
	logic [cdc_pkg::DIV_DEN_W-1:0] den_q;
	logic [31:0]                   rcp_q;
	logic [cdc_pkg::DIV_QUO_W-1:0] qe_q;
	logic [cdc_pkg::DIV_QUO_W-1:0] quo_q;
	logic [cdc_pkg::DIV_DEN_W-1:0] rem_q;
	logic                          busy_q;
	logic                          ph_q;

	logic [31:0]                   rcp;
	logic [63:0]                   prod;
	logic [cdc_pkg::DIV_NUM_W-1:0] part;

	always_comb begin
		unique case (req.den)
			cdc_pkg::DIV_GREG: rcp = cdc_pkg::RCP_GREG;
			cdc_pkg::DIV_JUL:  rcp = cdc_pkg::RCP_JUL;
			cdc_pkg::DIV_MON:  rcp = cdc_pkg::RCP_MON;
			cdc_pkg::DIV_DAY:  rcp = cdc_pkg::RCP_DAY;
			cdc_pkg::DIV_YR:   rcp = cdc_pkg::RCP_YR;
			cdc_pkg::DIV_WEEK: rcp = cdc_pkg::RCP_WEEK;
			default:           rcp = '0;
		endcase
	end

	assign prod = 64'(num_q) * 64'(rcp_q);
	// remainder of the estimate, below twice the divisor
	assign part = num_q - cdc_pkg::DIV_NUM_W'(qe_q) * cdc_pkg::DIV_NUM_W'(den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			ph_q   <= 1'b0;
		end else if (busy_q) begin
			if (!ph_q) begin
				ph_q <= 1'b1;
			end else begin
				ph_q   <= 1'b0;
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rcp_q <= rcp;
		end else if (busy_q && !ph_q) begin
			qe_q <= prod[32 +: cdc_pkg::DIV_QUO_W];
		end else if (busy_q && ph_q) begin
			if (part >= cdc_pkg::DIV_NUM_W'(den_q)) begin
				quo_q <= qe_q + 1'b1;
				rem_q <= cdc_pkg::DIV_DEN_W'(part - cdc_pkg::DIV_NUM_W'(den_q));
			end else begin
				quo_q <= qe_q;
				rem_q <= cdc_pkg::DIV_DEN_W'(part);
			end
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

### rtl/core/calendar_date_calculator.sv
// Calendar date calculator. Holds one Gregorian date (11 May 1959 after reset) and
// answers each request beat with one result beat. A load (req_type 0) checks the
// date by converting it to a Julian day number and back and stores it if it
// survives with its year in 1..9999, else stores 11 May 1959; a shift (req_type 1)
// adds day_offset and keeps the old date if the year would leave 1..9999. The result
// carries the stored date, its day of year, weekday (0 Sunday), the input date minus
// the stored date in days (saturated to +/-4000000) and a reject flag. One request is
// handled at a time: the result beat is registered as the block returns to idle, where
// it takes the next request. The time goes mostly to the six divisions by constants,
// all on one shared reciprocal-multiply divider. A result still held at the output
// stalls the next request at its last step.
module calendar_date_calculator (
	input  logic          clk,
	input  logic          arst_n,
	cdc_req_if.sink       req,
	cdc_res_if.source     res
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_J0   = 5'd1;
	localparam logic [4:0] S_J1   = 5'd2;
	localparam logic [4:0] S_J2   = 5'd3;
	localparam logic [4:0] S_K0   = 5'd4;
	localparam logic [4:0] S_K1   = 5'd5;
	localparam logic [4:0] S_K2   = 5'd6;
	localparam logic [4:0] S_F0   = 5'd7;
	localparam logic [4:0] S_F1   = 5'd8;
	localparam logic [4:0] S_F2   = 5'd9;
	localparam logic [4:0] S_F3   = 5'd10;
	localparam logic [4:0] S_F4   = 5'd11;
	localparam logic [4:0] S_F5   = 5'd12;
	localparam logic [4:0] S_F6   = 5'd13;
	localparam logic [4:0] S_F7   = 5'd14;
	localparam logic [4:0] S_F8   = 5'd15;
	localparam logic [4:0] S_F9   = 5'd16;
	localparam logic [4:0] S_F10  = 5'd17;
	localparam logic [4:0] S_F11  = 5'd18;
	localparam logic [4:0] S_F12  = 5'd19;
	localparam logic [4:0] S_G0   = 5'd20;
	localparam logic [4:0] S_G1   = 5'd21;
	localparam logic [4:0] S_G2   = 5'd22;
	localparam logic [4:0] S_G3   = 5'd23;
	localparam logic [4:0] S_G4   = 5'd24;

	logic [4:0]  state_q;
	logic        req_q;
	logic [3:0]  im_q;
	logic [4:0]  id_q;
	logic [13:0] iy_q;
	logic [20:0] off_q;
	logic [3:0]  st_month_q;
	logic [4:0]  st_day_q;
	logic [13:0] st_year_q;
	logic [22:0] jin_q;
	logic [23:0] cand_q;
	logic [23:0] l_q;
	logic [7:0]  n_q;
	logic [6:0]  i_q;
	logic [3:0]  j_q;
	logic [8:0]  k_q;
	logic [4:0]  fm_q;
	logic signed [15:0] fy_q;
	logic [22:0] jd_q;
	logic [8:0]  yday_q;
	logic        rej_q;

	logic        out_vld_q;
	logic [3:0]  out_month_q;
	logic [4:0]  out_day_q;
	logic [13:0] out_year_q;
	logic [8:0]  out_yday_q;
	logic [2:0]  out_wday_q;
	logic [22:0] out_apart_q;
	logic        out_rej_q;

	logic [3:0]  dn_m;
	logic [4:0]  dn_d;
	logic [13:0] dn_y;
	logic [22:0] dn_jd;

	cdc_pkg::div_req_t               div_req;
	logic                            div_busy;
	logic [cdc_pkg::DIV_QUO_W-1:0]   div_quo;
	logic [cdc_pkg::DIV_DEN_W-1:0]   div_rem;

	logic [23:0] l_init;
	logic [25:0] f2_prod;
	logic [17:0] f5_prod;
	logic [1:0]  ll;
	logic        load_ok;
	logic        shift_ok;
	logic [24:0] cand_sum;
	logic signed [24:0] apart;
	logic [22:0] apart_sat;
	logic        out_load;

	cdc_daynum u_daynum (
		.clk (clk),
		.m   (dn_m),
		.d   (dn_d),
		.y   (dn_y),
		.jd  (dn_jd)
	);

	cdc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	always_comb begin
		dn_m = st_month_q;
		dn_d = st_day_q;
		dn_y = st_year_q;
		if (state_q == S_J0) begin
			dn_m = im_q;
			dn_d = id_q;
			dn_y = iy_q;
		end else if (state_q == S_G1) begin
			dn_m = 4'd1;
			dn_d = 5'd1;
		end
	end

	assign l_init = cand_q + 24'd68569;

	always_comb begin
		div_req = '0;
		unique case (state_q)
			S_F0: begin
				div_req.start = 1'b1;
				div_req.num   = 32'(l_init) << 2;
				div_req.den   = cdc_pkg::DIV_GREG;
			end
			S_F3: begin
				div_req.start = 1'b1;
				div_req.num   = (32'(l_q) + 32'd1) * 32'd4000;
				div_req.den   = cdc_pkg::DIV_JUL;
			end
			S_F6: begin
				div_req.start = 1'b1;
				div_req.num   = 32'(l_q) * 32'd80;
				div_req.den   = cdc_pkg::DIV_MON;
			end
			S_F8: begin
				div_req.start = 1'b1;
				div_req.num   = 32'(j_q) * 32'd2447;
				div_req.den   = cdc_pkg::DIV_DAY;
			end
			S_F10: begin
				div_req.start = 1'b1;
				div_req.num   = 32'(j_q);
				div_req.den   = cdc_pkg::DIV_YR;
			end
			S_G3: begin
				div_req.start = 1'b1;
				div_req.num   = 32'(jd_q) + 32'd1;
				div_req.den   = cdc_pkg::DIV_WEEK;
			end
			default: div_req = '0;
		endcase
	end

	assign f2_prod  = 26'(n_q) * 26'd146097 + 26'd3;
	assign f5_prod  = 18'(i_q) * 18'd1461;
	assign ll       = div_quo[1:0];
	assign cand_sum = {2'b00, dn_jd} + {{4{off_q[20]}}, off_q};

	assign load_ok = (fm_q == {1'b0, im_q}) && (k_q == {4'd0, id_q})
		&& (fy_q == $signed({2'b00, iy_q})) && (iy_q >= cdc_pkg::YEAR_MIN)
		&& (iy_q <= cdc_pkg::YEAR_MAX);
	assign shift_ok = (fy_q >= 16'sd1) && (fy_q <= 16'sd9999);

	assign apart = $signed({2'b00, jin_q}) - $signed({2'b00, jd_q});
	always_comb begin
		if (apart > 25'sd4000000) begin
			apart_sat = 23'(cdc_pkg::APART_LIM);
		end else if (apart < -25'sd4000000) begin
			apart_sat = 23'(-cdc_pkg::APART_LIM);
		end else begin
			apart_sat = apart[22:0];
		end
	end

	assign out_load = (state_q == S_G4) && !div_busy && (!out_vld_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			st_month_q <= cdc_pkg::DEF_MONTH;
			st_day_q   <= cdc_pkg::DEF_DAY;
			st_year_q  <= cdc_pkg::DEF_YEAR;
		end else begin
			unique case (state_q)
				S_IDLE: if (req.valid) state_q <= S_J0;
				S_J0:   state_q <= S_J1;
				S_J1:   state_q <= S_J2;
				S_J2:   state_q <= req_q ? S_K0 : S_F0;
				S_K0:   state_q <= S_K1;
				S_K1:   state_q <= S_K2;
				S_K2:   state_q <= S_F0;
				S_F0:   state_q <= S_F1;
				S_F1:   if (!div_busy) state_q <= S_F2;
				S_F2:   state_q <= S_F3;
				S_F3:   state_q <= S_F4;
				S_F4:   if (!div_busy) state_q <= S_F5;
				S_F5:   state_q <= S_F6;
				S_F6:   state_q <= S_F7;
				S_F7:   if (!div_busy) state_q <= S_F8;
				S_F8:   state_q <= S_F9;
				S_F9:   if (!div_busy) state_q <= S_F10;
				S_F10:  state_q <= S_F11;
				S_F11:  if (!div_busy) state_q <= S_F12;
				S_F12: begin
					state_q <= S_G0;
					if (!req_q) begin
						if (load_ok) begin
							st_month_q <= im_q;
							st_day_q   <= id_q;
							st_year_q  <= iy_q;
						end else begin
							st_month_q <= cdc_pkg::DEF_MONTH;
							st_day_q   <= cdc_pkg::DEF_DAY;
							st_year_q  <= cdc_pkg::DEF_YEAR;
						end
					end else if (shift_ok) begin
						st_month_q <= fm_q[3:0];
						st_day_q   <= k_q[4:0];
						st_year_q  <= fy_q[13:0];
					end
				end
				S_G0:   state_q <= S_G1;
				S_G1:   state_q <= S_G2;
				S_G2:   state_q <= S_G3;
				S_G3:   state_q <= S_G4;
				S_G4:   if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			req_q <= req.req_type;
			im_q  <= req.date_month;
			id_q  <= req.date_day;
			iy_q  <= req.date_year;
			off_q <= req.day_offset;
		end
		if (state_q == S_J2) begin
			jin_q  <= dn_jd;
			cand_q <= {1'b0, dn_jd};
		end
		if (state_q == S_K2) begin
			cand_q <= cand_sum[23:0];
		end
		if (state_q == S_F0) begin
			l_q <= l_init;
		end
		if (state_q == S_F1 && !div_busy) begin
			n_q <= div_quo[7:0];
		end
		if (state_q == S_F2) begin
			l_q <= l_q - 24'(f2_prod[25:2]);
		end
		if (state_q == S_F4 && !div_busy) begin
			i_q <= div_quo[6:0];
		end
		if (state_q == S_F5) begin
			l_q <= l_q - 24'(f5_prod[17:2]) + 24'd31;
		end
		if (state_q == S_F7 && !div_busy) begin
			j_q <= div_quo[3:0];
		end
		if (state_q == S_F9 && !div_busy) begin
			k_q <= 9'(l_q - 24'(div_quo[8:0]));
		end
		if (state_q == S_F11 && !div_busy) begin
			fm_q <= 5'(j_q) + 5'd2 - 5'(ll) * 5'd12;
			fy_q <= (16'(n_q) - 16'sd49) * 16'sd100 + $signed(16'(i_q))
				+ $signed(16'(ll));
		end
		if (state_q == S_F12) begin
			rej_q <= req_q ? !shift_ok : !load_ok;
		end
		if (state_q == S_G2) begin
			jd_q <= dn_jd;
		end
		if (state_q == S_G3) begin
			yday_q <= 9'(jd_q - dn_jd + 23'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_month_q <= st_month_q;
			out_day_q   <= st_day_q;
			out_year_q  <= st_year_q;
			out_yday_q  <= yday_q;
			out_wday_q  <= div_rem[2:0];
			out_apart_q <= apart_sat;
			out_rej_q   <= rej_q;
		end
	end

	assign req.ready         = (state_q == S_IDLE);
	assign res.valid         = out_vld_q;
	assign res.cur_month     = out_month_q;
	assign res.cur_day       = out_day_q;
	assign res.cur_year      = out_year_q;
	assign res.year_day      = out_yday_q;
	assign res.week_day      = out_wday_q;
	assign res.days_apart    = $signed(out_apart_q);
	assign res.date_rejected = out_rej_q;

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_year_q >= cdc_pkg::YEAR_MIN) && (st_year_q <= cdc_pkg::YEAR_MAX))
		else $error("stored year out of range");

	a_month_day: assert property (@(posedge clk) disable iff (!arst_n)
		(st_month_q >= 4'd1) && (st_month_q <= 4'd12) && (st_day_q >= 5'd1)
		&& (st_day_q <= 5'd31))
		else $error("stored month or day out of range");

	a_out_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.week_day <= 3'd6) && (res.year_day >= 9'd1)
		&& (res.year_day <= 9'd366))
		else $error("weekday or day of year out of range");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_busy)
		else $error("divider started while busy");

endmodule

### tb/cdc_scoreboard.sv
`timescale 1ns / 100ps

module cdc_scoreboard (
	input  logic clk,
	input  logic arst_n,
	cdc_req_if   req,
	cdc_res_if   res,
	output int   fail_count,
	output int   pending,
	output int   n_loads,
	output int   n_shifts,
	output int   n_rejects
);

	typedef struct packed {
		logic [3:0]         cur_month;
		logic [4:0]         cur_day;
		logic [13:0]        cur_year;
		logic [8:0]         year_day;
		logic [2:0]         week_day;
		logic signed [22:0] days_apart;
		logic               date_rejected;
	} date_result_t;

	date_result_t expected_q[$];

	longint held_month, held_day, held_year;

	// Fliegel-Van Flandern, integer division truncates toward zero
	function automatic longint to_day_count(longint m, longint d, longint y);
		longint a;
		a = (m - 14) / 12;
		return d - 32075 + 1461 * (y + 4800 + a) / 4 + 367 * (m - 2 - a * 12) / 12
			- 3 * ((y + 4900 + a) / 100) / 4;
	endfunction

	function automatic void from_day_count(input longint jd, output longint m,
		output longint d, output longint y);
		longint l, n, i, j, k;
		l = jd + 68569;
		n = 4 * l / 146097;
		l = l - (146097 * n + 3) / 4;
		i = 4000 * (l + 1) / 1461001;
		l = l - 1461 * i / 4 + 31;
		j = 80 * l / 2447;
		k = l - 2447 * j / 80;
		l = j / 11;
		j = j + 2 - 12 * l;
		i = 100 * (n - 49) + i + l;
		y = i;
		m = j;
		d = k;
	endfunction

	function automatic date_result_t predict_date(logic kind, logic [3:0] mo, logic [4:0] dy,
		logic [13:0] yr, logic signed [20:0] off);
		date_result_t r;
		longint im, id, iy, m, d, y, jd, jin, apart;
		logic rej;
		im  = mo;
		id  = dy;
		iy  = yr;
		rej = 1'b0;
		if (kind == 1'b0) begin
			from_day_count(to_day_count(im, id, iy), m, d, y);
			if (m == im && d == id && y == iy && iy >= longint'(cdc_pkg::YEAR_MIN)
				&& iy <= longint'(cdc_pkg::YEAR_MAX)) begin
				held_month = im;
				held_day   = id;
				held_year  = iy;
			end else begin
				held_month = cdc_pkg::DEF_MONTH;
				held_day   = cdc_pkg::DEF_DAY;
				held_year  = cdc_pkg::DEF_YEAR;
				rej = 1'b1;
			end
		end else begin
			jd = to_day_count(held_month, held_day, held_year) + longint'(off);
			from_day_count(jd, m, d, y);
			if (y >= longint'(cdc_pkg::YEAR_MIN) && y <= longint'(cdc_pkg::YEAR_MAX)) begin
				held_month = m;
				held_day   = d;
				held_year  = y;
			end else begin
				rej = 1'b1;
			end
		end
		jd    = to_day_count(held_month, held_day, held_year);
		jin   = to_day_count(im, id, iy);
		apart = jin - jd;
		if (apart > cdc_pkg::APART_LIM)  apart = cdc_pkg::APART_LIM;
		if (apart < -cdc_pkg::APART_LIM) apart = -cdc_pkg::APART_LIM;
		r.cur_month     = held_month[3:0];
		r.cur_day       = held_day[4:0];
		r.cur_year      = held_year[13:0];
		r.year_day      = 9'(jd - to_day_count(1, 1, held_year) + 1);
		r.week_day      = 3'((jd + 1) % 7);
		r.days_apart    = 23'(apart);
		r.date_rejected = rej;
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		date_result_t e, a;
		if (!arst_n) begin
			held_month = cdc_pkg::DEF_MONTH;
			held_day   = cdc_pkg::DEF_DAY;
			held_year  = cdc_pkg::DEF_YEAR;
			expected_q.delete();
			fail_count = 0;
			n_loads    = 0;
			n_shifts   = 0;
			n_rejects  = 0;
		end else begin
			if (req.valid && req.ready) begin
				e = predict_date(req.req_type, req.date_month, req.date_day, req.date_year,
					req.day_offset);
				expected_q.push_back(e);
				if (req.req_type) n_shifts++;
				else n_loads++;
				if (e.date_rejected) n_rejects++;
			end
			if (res.valid && res.ready) begin
				a = '{res.cur_month, res.cur_day, res.cur_year, res.year_day, res.week_day,
					res.days_apart, res.date_rejected};
				if (expected_q.size() == 0) begin
					$display("%0t: result beat with nothing expected: %p", $time, a);
					fail_count++;
				end else begin
					e = expected_q.pop_front();
					if (a !== e) begin
						$display("%0t: mismatch expected %p actual %p", $time, e, a);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

### tb/tb_calendar_date_calculator.sv
`timescale 1ns / 100ps

module tb_calendar_date_calculator;

	localparam int RANDOM_ITEMS = 1630;
	localparam int STALL_LIMIT  = 20000;
	localparam int HOLD_CYCLES  = 1500;

	logic clk;
	logic arst_n;
	int   fail_count, pending, n_loads, n_shifts, n_rejects;
	int   results_seen;
	int   idle_cycles;

	cdc_req_if req ();
	cdc_res_if res ();

	calendar_date_calculator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	cdc_scoreboard scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.res        (res),
		.fail_count (fail_count),
		.pending    (pending),
		.n_loads    (n_loads),
		.n_shifts   (n_shifts),
		.n_rejects  (n_rejects)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	task automatic send_date(logic kind, logic [3:0] mo, logic [4:0] dy, logic [13:0] yr,
		logic signed [20:0] off);
		int g;
		g = gap_len();
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		req.valid      <= 1'b1;
		req.req_type   <= kind;
		req.date_month <= mo;
		req.date_day   <= dy;
		req.date_year  <= yr;
		req.day_offset <= off;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	task automatic send_random();
		int p;
		logic [13:0] yr;
		p = $urandom_range(0, 99);
		if (p < 45) begin
			// mostly plausible loads, some days past month end
			yr = $urandom_range(0, 3) == 0 ? 14'($urandom_range(1, 40) * 100) :
				14'($urandom_range(1, 9999));
			send_date(1'b0, 4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)), yr,
				21'($urandom));
		end else if (p < 55) begin
			send_date(1'b0, 4'($urandom), 5'($urandom), 14'($urandom), 21'($urandom));
		end else if (p < 60) begin
			yr = $urandom_range(0, 1) ? 14'($urandom_range(1, 3)) :
				14'($urandom_range(9997, 9999));
			send_date(1'b0, 4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)), yr,
				21'($urandom));
		end else if (p < 85) begin
			send_date(1'b1, 4'($urandom), 5'($urandom), 14'($urandom_range(1, 9999)),
				21'(int'($urandom_range(0, 1600)) - 800));
		end else if (p < 95) begin
			send_date(1'b1, 4'($urandom_range(1, 12)), 5'($urandom_range(1, 28)),
				14'($urandom_range(1, 9999)), 21'(int'($urandom_range(0, 3000000)) - 1500000));
		end else begin
			send_date(1'b1, 4'($urandom), 5'($urandom), 14'($urandom), 21'($urandom));
		end
	endtask

	// result side: random back-pressure plus one long hold-off
	initial begin
		int g;
		bit held;
		held = 1'b0;
		res.ready = 1'b0;
		results_seen = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && results_seen == 40) begin
				held = 1'b1;
				res.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			g = gap_len();
			if (g > 0) begin
				res.ready <= 1'b0;
				repeat (g) @(negedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (res.valid && res.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results pending", idle_cycles,
				pending);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.req_type   = 1'b0;
		req.date_month = '0;
		req.date_day   = '0;
		req.date_year  = '0;
		req.day_offset = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset date, limits, leap rules, bad fields, saturation
		send_date(1'b1, 4'd5, 5'd11, 14'd1959, 21'sd0);
		send_date(1'b0, 4'd2, 5'd29, 14'd2000, 21'sd5);
		send_date(1'b0, 4'd2, 5'd29, 14'd1900, 21'sd0);
		send_date(1'b0, 4'd2, 5'd29, 14'd2024, 21'sd0);
		send_date(1'b0, 4'd0, 5'd10, 14'd2020, 21'sd0);
		send_date(1'b0, 4'd13, 5'd1, 14'd2020, 21'sd0);
		send_date(1'b0, 4'd15, 5'd31, 14'd16383, -21'sd1);
		send_date(1'b0, 4'd4, 5'd31, 14'd2021, 21'sd0);
		send_date(1'b0, 4'd6, 5'd0, 14'd2021, 21'sd0);
		send_date(1'b0, 4'd1, 5'd1, 14'd0, 21'sd0);
		send_date(1'b0, 4'd1, 5'd1, 14'd10000, 21'sd0);
		send_date(1'b0, 4'd12, 5'd31, 14'd9999, 21'sd0);
		send_date(1'b1, 4'd1, 5'd1, 14'd1, 21'sd1);
		send_date(1'b1, 4'd1, 5'd1, 14'd1, -21'sd1);
		send_date(1'b0, 4'd1, 5'd1, 14'd1, 21'sd0);
		send_date(1'b1, 4'd12, 5'd31, 14'd9999, -21'sd1);
		send_date(1'b1, 4'd12, 5'd31, 14'd9999, 21'sd1048575);
		send_date(1'b1, 4'd0, 5'd0, 14'd16383, -21'sd1048576);
		send_date(1'b0, 4'd12, 5'd31, 14'd9999, 21'sd0);
		send_date(1'b1, 4'd15, 5'd31, 14'd16383, -21'sd1048576);
		send_date(1'b1, 4'd1, 5'd1, 14'd1, 21'sd365);

		repeat (RANDOM_ITEMS) send_random();
		req.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);

		$display("covered %0d loads and %0d shifts, %0d of them rejected", n_loads, n_shifts,
			n_rejects);
		$display("%0d result beats checked, one long result hold-off", results_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
